### rtl/frame_row_span_encoder_macros.svh
// Assertion macros shared by the span encoder checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FRAME_ROW_SPAN_ENCODER_MACROS_SVH
`define FRAME_ROW_SPAN_ENCODER_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define FRSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("span encoder check failed");

// Next-cycle implication, quiet while reset is high
`define FRSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span encoder check failed");

// Next-cycle implication that also holds across reset
`define FRSE_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("span encoder check failed");

`endif

### rtl/frse_pkg.sv
// Package for the frame row span encoder: register indexes, format codes,
// display geometry. No dependencies.
package frse_pkg;

  // Default frame size
  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 128;

  // Display geometry
  localparam int DISP_W   = 320;
  localparam int DISP_H   = 240;
  localparam int SQUARE   = 240;
  localparam int SQ_LEFT  = (DISP_W - SQUARE) / 2;

  // Coordinate lookup tables cover every 8-bit frame coordinate
  localparam int COORD_W   = 8;
  localparam int TAB_DEPTH = 1 << COORD_W;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_ENABLE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MONO_SET_COLOR   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MONO_CLEAR_COLOR = 2'd3;

  // Pixel format codes; the unused code decodes as byte-swapped rgb565
  localparam logic [1:0] FMT_RGB565_SWAP = 2'd0;
  localparam logic [1:0] FMT_RGB332      = 2'd1;
  localparam logic [1:0] FMT_MONO        = 2'd2;

  localparam logic [15:0] MONO_SET_RESET = 16'hFFFF;

  typedef logic [15:0] color_t;

endpackage

### rtl/frame_row_span_encoder.sv
// Frame row span encoder: decodes pixels, merges equal-color runs per row
// and emits display rectangles. Depends on frse_pkg.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------------
//   pixel in  | pixel_valid / pixel_stall | raw_pixel
//   span out  | span_valid / span_stall   | span_x, span_y, span_width,
//             |                           | span_height, span_color, last
//   config    | wr_en                     | wr_index, wr_data
//
// One pixel is taken per cycle while pixel_stall is low. A pixel that ends a
// run and also ends a row yields two spans, held in both slots; pixel_stall
// stays high until the first has left. Spans go from a slot to the output register.
// Reset clears the run state, the span slots and the output register.
// An output stall backs up through the two span slots to pixel_stall.
module frame_row_span_encoder #(
  parameter int FRAME_WIDTH  = frse_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = frse_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [15:0] raw_pixel,
  output logic        span_valid,
  input  logic        span_stall,
  output logic [8:0]  span_x,
  output logic [7:0]  span_y,
  output logic [8:0]  span_width,
  output logic [7:0]  span_height,
  output logic [15:0] span_color,
  output logic        last,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  localparam int CW      = frse_pkg::COORD_W;
  localparam int COL_OFS = (frse_pkg::DISP_W - FRAME_WIDTH) / 2;
  localparam int ROW_OFS = (frse_pkg::DISP_H - FRAME_HEIGHT) / 2;

  // Configuration registers
  logic [1:0]       pixel_format;
  logic             scale_enable;
  frse_pkg::color_t mono_set_color;
  frse_pkg::color_t mono_clear_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format     <= frse_pkg::FMT_RGB565_SWAP;
      scale_enable     <= 1'b1;
      mono_set_color   <= frse_pkg::MONO_SET_RESET;
      mono_clear_color <= '0;
    end else if (wr_en) begin
      case (wr_index)
        frse_pkg::REG_PIXEL_FORMAT:     pixel_format     <= wr_data[1:0];
        frse_pkg::REG_SCALE_ENABLE:     scale_enable     <= wr_data[0];
        frse_pkg::REG_MONO_SET_COLOR:   mono_set_color   <= wr_data;
        frse_pkg::REG_MONO_CLEAR_COLOR: mono_clear_color <= wr_data;
        default: ;
      endcase
    end
  end

  // Pixel decode to rgb565
  frse_pkg::color_t pix_color;
  always_comb begin
    case (pixel_format)
      frse_pkg::FMT_RGB332:
        pix_color = {raw_pixel[7:5], 2'b00, raw_pixel[4:2], 3'b000,
                     raw_pixel[1:0], 3'b000};
      frse_pkg::FMT_MONO:
        pix_color = raw_pixel[0] ? mono_set_color : mono_clear_color;
      default:
        pix_color = {raw_pixel[7:0], raw_pixel[15:8]};
    endcase
  end

  // Run tracking state
  logic [CW-1:0]    column_count;
  logic [CW-1:0]    row_count;
  logic [CW-1:0]    run_start;
  frse_pkg::color_t run_color;

  logic             accept;
  logic             col_zero;
  logic             change;
  logic             row_end;
  logic [CW-1:0]    col_inc;
  logic [CW-1:0]    run_start_next;
  frse_pkg::color_t run_color_next;

  always_comb begin
    col_zero       = (column_count == '0);
    change         = !col_zero && (pix_color != run_color);
    row_end        = ({1'b0, column_count} + 9'd1) >= 9'(FRAME_WIDTH);
    col_inc        = column_count + 1'b1;
    run_start_next = col_zero ? '0 : (change ? column_count : run_start);
    run_color_next = (col_zero || change) ? pix_color : run_color;
  end

  assign accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      run_start    <= '0;
      run_color    <= '0;
    end else if (accept) begin
      run_start <= run_start_next;
      run_color <= run_color_next;
      if (row_end) begin
        column_count <= '0;
        row_count    <= (({1'b0, row_count} + 9'd1) >= 9'(FRAME_HEIGHT)) ?
                        '0 : row_count + 1'b1;
      end else begin
        column_count <= col_inc;
      end
    end
  end

  // Span slots: slot a is the run closed by a color change, slot b the
  // run flushed at row end. Both share the row of their pixel.
  logic             a_valid, b_valid;
  logic [CW-1:0]    a_x0, a_x1, b_x0, b_x1, hold_row;
  frse_pkg::color_t a_color, b_color;
  logic             move;
  logic             hold_free;

  assign move      = (a_valid || b_valid) && (!span_valid || !span_stall);
  assign hold_free = !(a_valid || b_valid) || (move && !(a_valid && b_valid));
  assign pixel_stall = !hold_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= change;
      b_valid <= row_end;
    end else if (move) begin
      if (a_valid) begin
        a_valid <= 1'b0;
      end else begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x0     <= run_start;
      a_x1     <= column_count;
      a_color  <= run_color;
      b_x0     <= run_start_next;
      b_x1     <= col_inc;
      b_color  <= run_color_next;
      hold_row <= row_count;
    end
  end

  // Scaled coordinate tables, built at elaboration
  logic [8:0] col_tab [frse_pkg::TAB_DEPTH];
  logic [7:0] row_tab [frse_pkg::TAB_DEPTH];

  for (genvar i = 0; i < frse_pkg::TAB_DEPTH; i++) begin : g_tab
    assign col_tab[i] = 9'(frse_pkg::SQ_LEFT +
                           (i * frse_pkg::SQUARE + FRAME_WIDTH - 1) / FRAME_WIDTH);
    assign row_tab[i] = 8'((i * frse_pkg::SQUARE + FRAME_HEIGHT - 1) / FRAME_HEIGHT);
  end

  // Map the selected slot to display coordinates. Mapped spans are never
  // empty: both maps rise strictly with the frame coordinate.
  logic [CW-1:0]    sel_x0, sel_x1, row_inc;
  frse_pkg::color_t sel_color;
  logic             sel_last;
  logic [8:0]       col_lo, col_hi;
  logic [7:0]       row_lo, row_hi;

  always_comb begin
    sel_x0    = a_valid ? a_x0 : b_x0;
    sel_x1    = a_valid ? a_x1 : b_x1;
    sel_color = a_valid ? a_color : b_color;
    sel_last  = !(a_valid && b_valid);
    row_inc   = hold_row + 1'b1;
    if (scale_enable) begin
      col_lo = col_tab[sel_x0];
      col_hi = col_tab[sel_x1];
      row_lo = row_tab[hold_row];
      row_hi = row_tab[row_inc];
    end else begin
      col_lo = 9'(COL_OFS) + {1'b0, sel_x0};
      col_hi = 9'(COL_OFS) + {1'b0, sel_x1};
      row_lo = 8'(ROW_OFS) + hold_row;
      row_hi = 8'(ROW_OFS) + row_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (move) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      span_x      <= col_lo;
      span_y      <= row_lo;
      span_width  <= col_hi - col_lo;
      span_height <= row_hi - row_lo;
      span_color  <= sel_color;
      last        <= sel_last;
    end
  end

endmodule

### rtl/frse_checker.sv
// Port-level checker for the frame row span encoder, bound to the top level.
// Depends on frame_row_span_encoder_macros.svh.
`include "frame_row_span_encoder_macros.svh"

module frse_checker (
  input logic        clk,
  input logic        rst,
  input logic        span_valid,
  input logic        span_stall,
  input logic [8:0]  span_x,
  input logic [7:0]  span_y,
  input logic [8:0]  span_width,
  input logic [7:0]  span_height,
  input logic [15:0] span_color,
  input logic        last
);

  logic [9:0] x_end;
  logic [8:0] y_end;

  assign x_end = {1'b0, span_x} + {1'b0, span_width};
  assign y_end = {1'b0, span_y} + {1'b0, span_height};

  // A stalled word keeps its x, width, color and last
  `FRSE_ASSERT_NXT(a_span_hold, clk, rst, span_valid && span_stall, span_valid && $stable(span_x) && $stable(span_width) && $stable(span_color) && $stable(last))

  // Every span covers at least one display pixel and stays on the panel
  `FRSE_ASSERT_IMP(a_span_nonempty, clk, rst, span_valid, span_width != 9'd0 && span_height != 8'd0)
  `FRSE_ASSERT_IMP(a_span_on_panel, clk, rst, span_valid, x_end <= 10'd320 && y_end <= 9'd240)

  // Reset empties the output register
  `FRSE_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !span_valid)

endmodule

bind frame_row_span_encoder frse_checker u_frse_checker (.*);
